// ===== sv/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue package
// Request and status codes, widths and the command and status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package deq_pkg;

   localparam int DEPTH_DEFAULT = 64;
   localparam int DATA_W        = 32;

   localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
   localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
   localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
   localparam logic [2:0] REQ_POP_BACK   = 3'd3;
   localparam logic [2:0] REQ_LIST       = 3'd4;

   localparam logic [1:0] STATUS_ELEM  = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic push_front;
      logic push_back;
      logic pop_front;
      logic pop_back;
      logic notice_empty;
      logic notice_full;
      logic list_start;
      logic list_read;
      logic list_emit;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic list_last;
      logic out_free;
   } stat_type;

endpackage

// ===== sv/deq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue controller
// Decodes request beats and sequences a listing, one element read and one
// result beat at a time.
// ----------------------------------------------------------------------------
module deq_ctrl
   import deq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_type,
   input  stat_type   stat,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE    = 3'b001,
      ST_LIST_RD = 3'b010,
      ST_LIST_WR = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_stall = (state_ff != ST_IDLE) || !stat.out_free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_type)
                  REQ_PUSH_FRONT: begin
                     cmd.notice_full = stat.full;
                     cmd.push_front  = !stat.full;
                  end
                  REQ_PUSH_BACK: begin
                     cmd.notice_full = stat.full;
                     cmd.push_back   = !stat.full;
                  end
                  REQ_POP_FRONT: begin
                     cmd.notice_empty = stat.empty;
                     cmd.pop_front    = !stat.empty;
                  end
                  REQ_POP_BACK: begin
                     cmd.notice_empty = stat.empty;
                     cmd.pop_back     = !stat.empty;
                  end
                  REQ_LIST: begin
                     cmd.notice_empty = stat.empty;
                     cmd.list_start   = !stat.empty;
                     if (!stat.empty) begin
                        state_in = ST_LIST_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LIST_RD: begin
            cmd.list_read = 1'b1;
            state_in      = ST_LIST_WR;
         end
         ST_LIST_WR: begin
            if (stat.out_free) begin
               cmd.list_emit = 1'b1;
               state_in      = stat.list_last ? ST_IDLE : ST_LIST_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/deq_datapath.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue datapath
// Circular element store with front pointer and count, listing walker and
// the result output register.
// ----------------------------------------------------------------------------
module deq_datapath
   import deq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output stat_type                 stat,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic                     rsp_stall,
   output logic                     rsp_valid,
   output logic [1:0]               rsp_status,
   output logic signed [DATA_W-1:0] rsp_element,
   output logic                     rsp_last
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] mem_rd_ff;

   logic [PW-1:0] front_ff;
   logic [PW-1:0] front_in;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic [PW-1:0] list_ptr_ff;
   logic [PW-1:0] list_ptr_in;
   logic [CW-1:0] remain_ff;
   logic [CW-1:0] remain_in;

   logic [PW:0]   back_sum;
   logic [PW-1:0] back_addr;
   logic [PW-1:0] front_dec;
   logic [PW-1:0] front_inc;
   logic [PW-1:0] list_inc;

   logic                     wr_en;
   logic [PW-1:0]            wr_addr;

   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic [1:0]               rsp_status_ff;
   logic signed [DATA_W-1:0] rsp_element_ff;
   logic                     rsp_last_ff;

   assign back_sum  = {1'b0, front_ff} + (PW + 1)'(count_ff);
   assign back_addr = (back_sum >= (PW + 1)'(DEPTH)) ?
                      PW'(back_sum - (PW + 1)'(DEPTH)) : PW'(back_sum);
   assign front_dec = (front_ff == '0) ? PW'(DEPTH - 1) : front_ff - 1'b1;
   assign front_inc = (front_ff == PW'(DEPTH - 1)) ? '0 : front_ff + 1'b1;
   assign list_inc  = (list_ptr_ff == PW'(DEPTH - 1)) ? '0 : list_ptr_ff + 1'b1;

   assign wr_en   = cmd.push_front || cmd.push_back;
   assign wr_addr = cmd.push_front ? front_dec : back_addr;

   always_comb begin
      front_in    = front_ff;
      count_in    = count_ff;
      list_ptr_in = list_ptr_ff;
      remain_in   = remain_ff;
      if (cmd.push_front) begin
         front_in = front_dec;
         count_in = count_ff + 1'b1;
      end
      if (cmd.push_back || cmd.pop_back) begin
         count_in = cmd.push_back ? count_ff + 1'b1 : count_ff - 1'b1;
      end
      if (cmd.pop_front) begin
         front_in = front_inc;
         count_in = count_ff - 1'b1;
      end
      if (cmd.list_start) begin
         list_ptr_in = front_ff;
         remain_in   = count_ff;
      end
      if (cmd.list_emit) begin
         list_ptr_in = list_inc;
         remain_in   = remain_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= req_value;
      end
      if (cmd.list_read) begin
         mem_rd_ff <= mem[list_ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff    <= '0;
         count_ff    <= '0;
         list_ptr_ff <= '0;
         remain_ff   <= '0;
      end else begin
         front_ff    <= front_in;
         count_ff    <= count_in;
         list_ptr_ff <= list_ptr_in;
         remain_ff   <= remain_in;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.notice_empty || cmd.notice_full || cmd.list_emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.notice_empty || cmd.notice_full) begin
         rsp_status_ff  <= cmd.notice_full ? STATUS_FULL : STATUS_EMPTY;
         rsp_element_ff <= '0;
         rsp_last_ff    <= 1'b1;
      end else if (cmd.list_emit) begin
         rsp_status_ff  <= STATUS_ELEM;
         rsp_element_ff <= mem_rd_ff;
         rsp_last_ff    <= (remain_ff == CW'(1));
      end
   end

   assign stat.empty     = (count_ff == '0);
   assign stat.full      = (count_ff == CW'(DEPTH));
   assign stat.list_last = (remain_ff == CW'(1));
   assign stat.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_element = rsp_element_ff;
   assign rsp_last    = rsp_last_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("Element count exceeds the store depth.");

   a_front_range: assert property (@(posedge clock) disable iff (reset)
      front_ff < PW'(DEPTH - 1) || front_ff == PW'(DEPTH - 1))
      else $error("Front pointer left the store.");

   a_notice_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != STATUS_ELEM |->
         rsp_last_ff && rsp_element_ff == '0)
      else $error("A notice beat is not last or carries a nonzero element.");

   a_list_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.list_emit |-> remain_ff != '0)
      else $error("Listing emitted a beat with no element remaining.");

endmodule

// ===== sv/double_ended_queue_unit.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue unit
// Signed 32-bit deque in a circular store with push, pop and listing.
// ----------------------------------------------------------------------------
// A request beat on the req_ channel carries a request type and a value.
// Push front, push back, pop front and pop back give no result beat when
// they succeed. A push into a full store gives one full notice; a pop or a
// listing on an empty queue gives one empty notice. A listing gives one rsp_
// beat per element from front to back, rsp_last set on the final one; each
// element is first read from the element store and then loaded into the
// output register. Requests are held off by req_stall during a listing.
// Result beats sit in an output register, so a request beat is taken
// whenever that register is empty or being drained; while the receiver
// stalls a full register, req_stall stays high. A notice reaches rsp_valid
// in the cycle after its request beat. Unknown request types are dropped.
// Reset empties the queue at once; the store contents are not cleared and
// are only read after being written.
// ----------------------------------------------------------------------------
module double_ended_queue_unit
   import deq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [2:0]               req_type,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_status,
   output logic signed [DATA_W-1:0] rsp_element,
   output logic                     rsp_last
);

   cmd_type  cmd;
   stat_type stat;

   deq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_type  (req_type),
      .stat      (stat),
      .cmd       (cmd)
   );

   deq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_value   (req_value),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_status  (rsp_status),
      .rsp_element (rsp_element),
      .rsp_last    (rsp_last)
   );

endmodule
